FILE: hw/rtl/srw_pkg.sv
// Shared types and constants for the selective-repeat receiver window.
`timescale 1ns / 1ps

package srw_pkg;

  // Frame sequence numbers and the width of the released-run count on the port.
  localparam int SEQ_W      = 31;
  localparam int CNT_OUT_W  = 9;
  localparam int STATUS_W   = 3;
  localparam int WINDOW_DEF = 256;

  // Classification of a received frame.
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_IN_ORDER = 3'd0;
  localparam status_t ST_OLD      = 3'd1;
  localparam status_t ST_FUTURE   = 3'd2;
  localparam status_t ST_ALREADY  = 3'd3;
  localparam status_t ST_BEYOND   = 3'd4;

  // Access request from the controller to the held-frame map.
  typedef struct packed {
    logic rd;
    logic wr;
    logic wr_bit;
  } map_ctl_t;

endpackage

FILE: hw/rtl/srw_held_map.sv
// Held-frame bitmap: one-bit synchronous memory with a clearing pass after reset.
`timescale 1ns / 1ps

module srw_held_map #(
  parameter int WINDOW = srw_pkg::WINDOW_DEF,
  parameter int AW     = $clog2(WINDOW)
) (
  input  logic             clk,
  input  logic             rst,
  input  srw_pkg::map_ctl_t ctl,
  input  logic [AW-1:0]    addr,
  output logic             q,
  output logic             busy
);

  localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

  logic          mem [WINDOW];
  logic [AW-1:0] clr_addr;

  // Clearing pass: one entry per cycle from reset until the last slot is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // Single port: the read data is registered, writes land at the end of the cycle.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (ctl.wr) begin
      mem[addr] <= ctl.wr_bit;
    end
    if (ctl.rd) begin
      q <= mem[addr];
    end
  end

endmodule

FILE: hw/rtl/selective_repeat_receiver_window_unit.sv
// Top level of the selective-repeat receiver window: classifier, run release and result register.
//
//   Channel | Signals                                        | Direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_stall, frame_index                | into block
//   out     | out_valid, out_stall, status, ack_valid,       | out of block
//           | ack_number, deliver_first, deliver_count       |
//
// An old or out-of-window frame goes from S_CLASS straight to S_DONE, a new future
// frame through S_CLASS, S_SLOT, S_READ, S_CHECK and S_DONE, and an in-order frame through
// S_CLASS, then S_READ and S_CHECK once per map probe, then S_DONE (one map read and one map
// write-back per released held frame through the single memory port). After reset a clearing
// pass runs over every map slot with in_stall high. The next beat is taken as soon as a result
// is in the output register; a stalled result holds and the following item waits in its last step.
`timescale 1ns / 1ps

module selective_repeat_receiver_window_unit #(
  parameter int WINDOW = srw_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [srw_pkg::SEQ_W-1:0]       frame_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output srw_pkg::status_t                status,
  output logic                            ack_valid,
  output logic [srw_pkg::SEQ_W-1:0]       ack_number,
  output logic [srw_pkg::SEQ_W-1:0]       deliver_first,
  output logic [srw_pkg::CNT_OUT_W-1:0]   deliver_count
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = srw_pkg::SEQ_W;

  localparam logic [AW-1:0]   SLOT_LAST = AW'(WINDOW - 1);
  localparam logic [CW-1:0]   WIN_CNT   = CW'(WINDOW);
  localparam logic [AW:0]     WIN_SUM   = (AW + 1)'(WINDOW);
  localparam logic [SW:0]     WIN_DIFF  = (SW + 1)'(WINDOW);
  localparam logic [SW-1:0]   SEQ_MAX   = '1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLASS = 6'b000010,
    S_SLOT  = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state;
  logic [SW-1:0]     frame;
  logic [SW-1:0]     next_exp;
  logic [AW-1:0]     next_slot;
  logic [AW-1:0]     slot_inc;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     diff_lo;
  logic [SW:0]       diff;
  logic [AW:0]       slot_sum;
  srw_pkg::status_t  cls;
  logic [SW-1:0]     first;
  logic [CW-1:0]     count;
  logic              run_more;
  logic              map_q;
  logic              map_busy;
  srw_pkg::map_ctl_t map_ctl;
  logic              out_free;

  // Held-frame map.
  srw_held_map #(
    .WINDOW (WINDOW),
    .AW     (AW)
  ) u_map (
    .clk  (clk),
    .rst  (rst),
    .ctl  (map_ctl),
    .addr (rd_addr),
    .q    (map_q),
    .busy (map_busy)
  );

  // Slot of the frame after next_exp; the sequence wrap restarts the slot at zero.
  always_comb begin
    if (next_exp == SEQ_MAX || next_slot == SLOT_LAST) begin
      slot_inc = '0;
    end else begin
      slot_inc = next_slot + 1'b1;
    end
  end

  // Distance ahead of the expected frame and the map slot of a future frame.
  assign diff     = {1'b0, frame} - {1'b0, next_exp};
  assign slot_sum = {1'b0, next_slot} + {1'b0, diff_lo};
  assign run_more = map_q && (count < WIN_CNT);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || map_busy;

  // Map accesses: read in S_READ, clear or set in S_CHECK. The next read is always
  // issued in a later state than the write-back, so no forwarding is needed.
  always_comb begin
    map_ctl = '0;
    if (state == S_READ) begin
      map_ctl.rd = 1'b1;
    end else if (state == S_CHECK) begin
      if (cls == srw_pkg::ST_IN_ORDER) begin
        map_ctl.wr     = run_more;
        map_ctl.wr_bit = 1'b0;
      end else begin
        map_ctl.wr     = !map_q;
        map_ctl.wr_bit = 1'b1;
      end
    end
  end

  // Sequencer and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_exp  <= '0;
      next_slot <= '0;
      out_valid <= 1'b0;
    end else begin
      // The result beat is raised as an item leaves S_DONE and dropped once taken.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !map_busy) begin
            frame <= frame_index;
            first <= '0;
            count <= '0;
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (frame == next_exp) begin
            cls       <= srw_pkg::ST_IN_ORDER;
            first     <= frame;
            count     <= CW'(1);
            next_exp  <= next_exp + 1'b1;
            next_slot <= slot_inc;
            rd_addr   <= slot_inc;
            state     <= S_READ;
          end else if (frame < next_exp) begin
            cls   <= srw_pkg::ST_OLD;
            state <= S_DONE;
          end else if (diff < WIN_DIFF) begin
            cls     <= srw_pkg::ST_FUTURE;
            diff_lo <= diff[AW-1:0];
            state   <= S_SLOT;
          end else begin
            cls   <= srw_pkg::ST_BEYOND;
            state <= S_DONE;
          end
        end
        S_SLOT: begin
          if (slot_sum >= WIN_SUM) begin
            rd_addr <= AW'(slot_sum - WIN_SUM);
          end else begin
            rd_addr <= slot_sum[AW-1:0];
          end
          state <= S_READ;
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (cls == srw_pkg::ST_IN_ORDER) begin
            if (run_more) begin
              count     <= count + 1'b1;
              next_exp  <= next_exp + 1'b1;
              next_slot <= slot_inc;
              rd_addr   <= slot_inc;
              state     <= S_READ;
            end else begin
              state <= S_DONE;
            end
          end else begin
            if (map_q) begin
              cls <= srw_pkg::ST_ALREADY;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register, loaded as the item leaves S_DONE.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status        <= cls;
      ack_valid     <= (cls != srw_pkg::ST_BEYOND);
      ack_number    <= (cls == srw_pkg::ST_BEYOND) ? '0 : frame;
      deliver_first <= first;
      deliver_count <= srw_pkg::CNT_OUT_W'(count);
    end
  end

  // An accepted beat always starts classification.
  a_accept_class: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_CLASS))
    else $error("accepted beat did not enter classification");

  // No beat is taken while the map clearing pass runs.
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    map_busy |-> in_stall)
    else $error("input not stalled during map clearing");

  // Only an out-of-window frame goes unacknowledged.
  a_ack_beyond: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == srw_pkg::ST_BEYOND) == !ack_valid))
    else $error("acknowledgement does not match status");

  // Frames are released only for an in-order arrival.
  a_deliver_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != srw_pkg::ST_IN_ORDER) |-> (deliver_count == '0))
    else $error("frames released for a frame not in order");

  // The tracked slot of the expected frame stays inside the map.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, next_slot} < WIN_SUM))
    else $error("expected-frame slot out of range");

endmodule

FILE: test/tb_selective_repeat_receiver_window_unit.sv
// Self-checking testbench for the selective-repeat receiver window unit.
`timescale 1ns / 1ps

module tb_selective_repeat_receiver_window_unit;

  localparam int WIN        = srw_pkg::WINDOW_DEF;
  localparam int FRAME_GOAL = 1700;
  localparam int IDLE_PCT   = 17;

  // Everything one result beat carries.
  typedef struct packed {
    srw_pkg::status_t                st;
    logic                            ackv;
    logic [srw_pkg::SEQ_W-1:0]       ackn;
    logic [srw_pkg::SEQ_W-1:0]       first;
    logic [srw_pkg::CNT_OUT_W-1:0]   cnt;
  } frame_outcome_t;

  // One directed row; the outcome is only used where known is set.
  typedef struct packed {
    logic [srw_pkg::SEQ_W-1:0] frame;
    logic                      known;
    frame_outcome_t            want;
  } drill_row_t;

  localparam int DRILL_ROWS = 18;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [srw_pkg::SEQ_W-1:0]     frame_index = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  srw_pkg::status_t              status;
  logic                          ack_valid;
  logic [srw_pkg::SEQ_W-1:0]     ack_number;
  logic [srw_pkg::SEQ_W-1:0]     deliver_first;
  logic [srw_pkg::CNT_OUT_W-1:0] deliver_count;

  // Shadow state of the window and the outcomes still owed by the block.
  logic [srw_pkg::SEQ_W-1:0] expected_seq = '0;
  bit               held_slot [WIN];
  frame_outcome_t   awaited_outcomes [$];
  int               mismatches = 0;
  int               frames_sent = 0;
  bit               calm = 1'b0;

  // Hand-checked opening sequence: the first rows follow directly from reset.
  drill_row_t drill [DRILL_ROWS] = '{
    '{31'd0,         1'b1, '{srw_pkg::ST_IN_ORDER, 1'b1, 31'd0,   31'd0, 9'd1}},
    '{31'd0,         1'b1, '{srw_pkg::ST_OLD,      1'b1, 31'd0,   31'd0, 9'd0}},
    '{31'd256,       1'b1, '{srw_pkg::ST_FUTURE,   1'b1, 31'd256, 31'd0, 9'd0}},
    '{31'd256,       1'b1, '{srw_pkg::ST_ALREADY,  1'b1, 31'd256, 31'd0, 9'd0}},
    '{31'd257,       1'b1, '{srw_pkg::ST_BEYOND,   1'b0, 31'd0,   31'd0, 9'd0}},
    '{31'h7FFF_FFFF, 1'b1, '{srw_pkg::ST_BEYOND,   1'b0, 31'd0,   31'd0, 9'd0}},
    '{31'd300,       1'b1, '{srw_pkg::ST_BEYOND,   1'b0, 31'd0,   31'd0, 9'd0}},
    '{31'd3,         1'b1, '{srw_pkg::ST_FUTURE,   1'b1, 31'd3,   31'd0, 9'd0}},
    '{31'd2,         1'b1, '{srw_pkg::ST_FUTURE,   1'b1, 31'd2,   31'd0, 9'd0}},
    '{31'd1,         1'b1, '{srw_pkg::ST_IN_ORDER, 1'b1, 31'd1,   31'd1, 9'd3}},
    '{31'h2AAA_AAAA, 1'b1, '{srw_pkg::ST_BEYOND,   1'b0, 31'd0,   31'd0, 9'd0}},
    '{31'h5555_5555, 1'b1, '{srw_pkg::ST_BEYOND,   1'b0, 31'd0,   31'd0, 9'd0}},
    '{31'd255,       1'b0, '0},
    '{31'd259,       1'b0, '0},
    '{31'd260,       1'b0, '0},
    '{31'd4,         1'b0, '0},
    '{31'd2,         1'b0, '0},
    '{31'd255,       1'b0, '0}
  };

  selective_repeat_receiver_window_unit #(
    .WINDOW(WIN)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .frame_index   (frame_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .ack_valid     (ack_valid),
    .ack_number    (ack_number),
    .deliver_first (deliver_first),
    .deliver_count (deliver_count)
  );

  always #10 clk = ~clk;

  // Classifies one frame against the shadow window and advances it.
  function automatic frame_outcome_t classify_frame(input logic [srw_pkg::SEQ_W-1:0] f);
    frame_outcome_t            r;
    logic [srw_pkg::SEQ_W:0]   ahead;
    int                        run;
    r      = '0;
    r.ackv = 1'b1;
    r.ackn = f;
    ahead  = {1'b0, f} - {1'b0, expected_seq};
    if (f == expected_seq) begin
      r.st         = srw_pkg::ST_IN_ORDER;
      r.first      = f;
      run          = 1;
      expected_seq = expected_seq + 1'b1;
      // Release the run of held frames that follows the expected one.
      while (run < WIN && held_slot[int'(expected_seq % WIN)]) begin
        held_slot[int'(expected_seq % WIN)] = 1'b0;
        run++;
        expected_seq = expected_seq + 1'b1;
      end
      r.cnt = srw_pkg::CNT_OUT_W'(run);
    end else if (f < expected_seq) begin
      r.st = srw_pkg::ST_OLD;
    end else if (ahead < WIN) begin
      if (held_slot[int'(f % WIN)]) begin
        r.st = srw_pkg::ST_ALREADY;
      end else begin
        r.st = srw_pkg::ST_FUTURE;
        held_slot[int'(f % WIN)] = 1'b1;
      end
    end else begin
      r.st   = srw_pkg::ST_BEYOND;
      r.ackv = 1'b0;
      r.ackn = '0;
    end
    return r;
  endfunction

  // Offers one frame beat, waits for it to be taken, then records its outcome.
  task automatic send_frame(input logic [srw_pkg::SEQ_W-1:0] f, input logic known,
                            input frame_outcome_t want);
    frame_outcome_t got;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    frame_index <= f;
    do @(posedge clk); while (!(in_valid && !in_stall));
    got = classify_frame(f);
    awaited_outcomes.push_back(known ? want : got);
    frames_sent++;
  endtask

  task automatic send_plain(input logic [srw_pkg::SEQ_W-1:0] f);
    send_frame(f, 1'b0, '0);
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  // Single frame of an arbitrary kind: old, inside, just past or far outside the window.
  task automatic send_noise();
    logic [srw_pkg::SEQ_W-1:0] f;
    case ($urandom_range(5))
      0: f = (expected_seq == 0) ? '0 :
             srw_pkg::SEQ_W'($urandom_range(int'(expected_seq) - 1));
      1: f = expected_seq + srw_pkg::SEQ_W'($urandom_range(1, WIN - 1));
      2: f = expected_seq + srw_pkg::SEQ_W'(WIN + $urandom_range(0, 3));
      3: f = srw_pkg::SEQ_W'($urandom);
      4: f = expected_seq - 1'b1;
      default: f = expected_seq + srw_pkg::SEQ_W'(WIN - 1);
    endcase
    send_plain(f);
  endtask

  // Sends frames base .. base+n-1 (from base+1 with skip_first) in shuffled order, with the odd stray beat.
  task automatic send_burst(input int n, input logic skip_first);
    logic [srw_pkg::SEQ_W-1:0] order [$];
    logic [srw_pkg::SEQ_W-1:0] base;
    logic [srw_pkg::SEQ_W-1:0] tmp;
    int                        j;
    base = expected_seq;
    order.delete();
    for (int i = skip_first ? 1 : 0; i < n; i++) begin
      order.push_back(base + srw_pkg::SEQ_W'(i));
    end
    for (int i = order.size() - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      send_plain(order[i]);
      if ($urandom_range(99) < 8) send_noise();
    end
  endtask

  // Receiver stalls at random except during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Each accepted result beat is compared with the oldest owed outcome.
  always @(posedge clk) begin
    frame_outcome_t w;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        $error("unexpected result beat: status %0d ack_number %0d", status, ack_number);
        mismatches++;
      end else begin
        w = awaited_outcomes.pop_front();
        if (status !== w.st) begin
          $error("status: expected %0d, got %0d", w.st, status);
          mismatches++;
        end
        if (ack_valid !== w.ackv) begin
          $error("ack_valid: expected %0d, got %0d", w.ackv, ack_valid);
          mismatches++;
        end
        if (ack_number !== w.ackn) begin
          $error("ack_number: expected %0d, got %0d", w.ackn, ack_number);
          mismatches++;
        end
        if (deliver_first !== w.first) begin
          $error("deliver_first: expected %0d, got %0d", w.first, deliver_first);
          mismatches++;
        end
        if (deliver_count !== w.cnt) begin
          $error("deliver_count: expected %0d, got %0d", w.cnt, deliver_count);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: reset, the directed rows, then random frame sequences.
  initial begin
    int pick;
    bit drained_mid;
    drained_mid = 1'b0;
    foreach (held_slot[i]) held_slot[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (drill[i]) send_frame(drill[i].frame, drill[i].known, drill[i].want);

    // Fill the whole window out of order, then release it in one long run.
    send_burst(WIN, 1'b1);
    wait_drained();
    send_plain(expected_seq);

    while (frames_sent < FRAME_GOAL) begin
      calm = (frames_sent >= 600 && frames_sent < 900);
      if (!drained_mid && frames_sent >= 1000) begin
        drained_mid = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_burst(WIN, 1'b1);
        send_plain(expected_seq);
      end else if (pick < 70) begin
        send_burst($urandom_range(1, 24), 1'b0);
      end else if (pick < 80) begin
        send_burst($urandom_range(2, 40), 1'b1);
      end else begin
        send_noise();
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: selective_repeat_receiver_window_unit.f
hw/rtl/srw_pkg.sv
hw/rtl/srw_held_map.sv
hw/rtl/selective_repeat_receiver_window_unit.sv
test/tb_selective_repeat_receiver_window_unit.sv
